// ===== design/x11sf_pkg.sv =====
// ----------------------------------------------------------------------------
// x11sf_pkg: shared types and constants for the X11 stream framer
// Holds the beat payload structs, packet kind codes, phase codes and the
// small byte-order and padding helpers.
// ----------------------------------------------------------------------------
package x11sf_pkg;

  // Counter widths for each direction
  localparam int unsigned CliCntW = 18;
  localparam int unsigned SrvCntW = 34;

  // Packet kinds reported on every output beat
  typedef enum logic [2:0] {
    KIND_SETUP_MSG   = 3'd0,
    KIND_REQUEST     = 3'd1,
    KIND_SETUP_REPLY = 3'd2,
    KIND_ERROR       = 3'd3,
    KIND_REPLY       = 3'd4,
    KIND_EVENT       = 3'd5
  } pkt_kind_e;

  typedef enum logic {
    CLI_SETUP   = 1'b0,
    CLI_REQUEST = 1'b1
  } cli_phase_e;

  typedef enum logic [1:0] {
    SRV_SETUP   = 2'd0,
    SRV_PACKETS = 2'd1
  } srv_phase_e;

  // Fixed protocol values
  localparam logic [7:0]         ASCII_LOWER_L  = 8'h6C;
  localparam logic [7:0]         SRV_CODE_ERROR = 8'd0;
  localparam logic [7:0]         SRV_CODE_REPLY = 8'd1;
  localparam logic [CliCntW-1:0] CLI_SETUP_HDR  = CliCntW'(12);
  localparam logic [CliCntW-1:0] CLI_REQ_HDR    = CliCntW'(4);
  localparam logic [SrvCntW-1:0] SRV_SETUP_HDR  = SrvCntW'(8);
  localparam logic [SrvCntW-1:0] SRV_PKT_BYTES  = SrvCntW'(32);
  localparam logic [SrvCntW-1:0] SRV_CNT_MAX    = {SrvCntW{1'b1}};

  typedef struct packed {
    logic       from_server;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic              direction;
    logic [7:0]        byte_out;
    pkt_kind_e         packet_kind;
    logic [SrvCntW-1:0] byte_offset;
    logic              last_byte;
    logic              bad_length;
    logic              little_endian;
  } out_beat_t;

  // Assemble a 16-bit word from two bytes in arrival order
  function automatic logic [15:0] order16(input logic [7:0] first,
                                          input logic [7:0] second,
                                          input logic       le);
    order16 = le ? {second, first} : {first, second};
  endfunction

  // Round a 16-bit byte count up to a multiple of four
  function automatic logic [CliCntW-1:0] pad4(input logic [15:0] n);
    logic [CliCntW-1:0] sum;
    sum  = CliCntW'(n) + CliCntW'(3);
    pad4 = {sum[CliCntW-1:2], 2'b00};
  endfunction

endpackage

// ===== design/x11_stream_framer.sv =====
// ----------------------------------------------------------------------------
// x11_stream_framer: byte-serial framer for both directions of an X11 link
// Tags each byte with its packet kind and offset, flags the last byte of
// each packet and a zero request length, and tracks the byte order.
// ----------------------------------------------------------------------------
//  channel | signals                            | beat
//  --------+------------------------------------+------------------------------
//  in      | in_valid_i, in_ready_o, in_data_i  | direction and one stream byte
//  out     | out_valid_o, out_ready_i, out_data_o | the byte with its tags
//
//  One byte per cycle sustained while the output keeps taking beats; each byte
//  passes through the input stage and then the result register.
//  Framing state moves only as a byte passes from the input stage into the
//  result register, so stalls on the output hold everything in place.
//  Reset puts both directions at the start of their setup phase, big-endian.
// ----------------------------------------------------------------------------
module x11_stream_framer #(
  parameter int unsigned REPLY_LEN_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  x11sf_pkg::in_beat_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output x11sf_pkg::out_beat_t out_data_o
);
  import x11sf_pkg::*;

  logic      stg_valid_q;
  in_beat_t  stg_data_q;
  logic      res_valid_q;
  out_beat_t res_data_q;
  out_beat_t res_data_d;
  logic      stg_advance;

  // Move the staged beat on when the result register is free or draining
  assign stg_advance = stg_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o  = !stg_valid_q || stg_advance;

  // Hold the accepted beat in the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      stg_data_q <= in_data_i;
    end
  end

  x11sf_core #(
    .REPLY_LEN_BITS(REPLY_LEN_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(stg_advance),
    .beat_i   (stg_data_q),
    .result_o (res_data_d)
  );

  // Load the result register; drop valid once the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (stg_advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_advance) begin
      res_data_q <= res_data_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_data_q;

endmodule

// ===== design/x11sf_core.sv =====
// ----------------------------------------------------------------------------
// x11sf_core: framing state and per-byte tagging
// Holds the per-direction counters, totals and header captures, and works
// out the tags of the staged byte; state advances when the byte moves on.
// ----------------------------------------------------------------------------
module x11sf_core #(
  parameter int unsigned REPLY_LEN_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  x11sf_pkg::in_beat_t  beat_i,
  output x11sf_pkg::out_beat_t result_o
);
  import x11sf_pkg::*;

  localparam logic [32:0] LenMaskW = (33'd1 << REPLY_LEN_BITS) - 33'd1;
  localparam logic [31:0] LenMask  = LenMaskW[31:0];

  cli_phase_e         cli_phase_q, cli_phase_d;
  logic [CliCntW-1:0] cli_count_q, cli_count_d;
  logic [CliCntW-1:0] cli_total_q, cli_total_d;
  logic [7:0]         cli_len_lo_q, cli_len_lo_d;
  logic [15:0]        cli_name_len_q, cli_name_len_d;
  srv_phase_e         srv_phase_q, srv_phase_d;
  logic [SrvCntW-1:0] srv_count_q, srv_count_d;
  logic [SrvCntW-1:0] srv_total_q, srv_total_d;
  pkt_kind_e          srv_kind_q, srv_kind_d;
  logic [31:0]        srv_len_acc_q, srv_len_acc_d;
  logic               endian_q, endian_d;

  // Work out next state and tags for the staged byte
  always_comb begin
    logic [7:0]         b;
    logic [15:0]        len16;
    logic [CliCntW-1:0] cli_tot;
    logic [SrvCntW-1:0] srv_tot;
    logic [31:0]        acc_now;
    logic [31:0]        len32;
    logic [34:0]        reply_tot;
    pkt_kind_e          kind;
    logic               last;
    logic               bad;

    cli_phase_d    = cli_phase_q;
    cli_count_d    = cli_count_q;
    cli_total_d    = cli_total_q;
    cli_len_lo_d   = cli_len_lo_q;
    cli_name_len_d = cli_name_len_q;
    srv_phase_d    = srv_phase_q;
    srv_count_d    = srv_count_q;
    srv_total_d    = srv_total_q;
    srv_kind_d     = srv_kind_q;
    srv_len_acc_d  = srv_len_acc_q;
    endian_d       = endian_q;

    b         = beat_i.data_byte;
    len16     = order16(cli_len_lo_q, b, endian_q);
    cli_tot   = cli_total_q;
    srv_tot   = srv_total_q;
    acc_now   = '0;
    len32     = '0;
    reply_tot = '0;
    kind      = KIND_SETUP_MSG;
    last      = 1'b0;
    bad       = 1'b0;

    if (!beat_i.from_server) begin
      // Client to server
      if (cli_phase_q == CLI_SETUP) begin
        kind = KIND_SETUP_MSG;
        if (cli_count_q == CliCntW'(0)) begin
          endian_d = (b == ASCII_LOWER_L);
        end
        if (cli_count_q == CliCntW'(6) || cli_count_q == CliCntW'(8)) begin
          cli_len_lo_d = b;
        end
        if (cli_count_q == CliCntW'(7)) begin
          cli_name_len_d = len16;
        end
        if (cli_count_q == CliCntW'(9)) begin
          cli_tot = CLI_SETUP_HDR + pad4(cli_name_len_q) + pad4(len16);
        end
      end else begin
        kind = KIND_REQUEST;
        if (cli_count_q == CliCntW'(2)) begin
          cli_len_lo_d = b;
        end
        if (cli_count_q == CliCntW'(3)) begin
          if (len16 == 16'd0) begin
            bad     = 1'b1;
            cli_tot = CLI_REQ_HDR;
          end else begin
            cli_tot = {len16, 2'b00};
          end
        end
      end
      last = ({1'b0, cli_count_q} + (CliCntW+1)'(1)) >= {1'b0, cli_tot};
      if (last) begin
        cli_count_d = '0;
        cli_phase_d = CLI_REQUEST;
        cli_total_d = CLI_REQ_HDR;
      end else begin
        cli_count_d = cli_count_q + CliCntW'(1);
        cli_total_d = cli_tot;
      end
    end else begin
      // Server to client
      if (srv_phase_q == SRV_SETUP) begin
        kind = KIND_SETUP_REPLY;
        if (srv_count_q == SrvCntW'(6)) begin
          srv_len_acc_d = {24'd0, b};
        end
        if (srv_count_q == SrvCntW'(7)) begin
          srv_tot = SRV_SETUP_HDR
                  + SrvCntW'({order16(srv_len_acc_q[7:0], b, endian_q), 2'b00});
        end
      end else begin
        kind = srv_kind_q;
        if (srv_count_q == SrvCntW'(0)) begin
          if (b == SRV_CODE_ERROR) begin
            kind = KIND_ERROR;
          end else if (b == SRV_CODE_REPLY) begin
            kind = KIND_REPLY;
          end else begin
            kind = KIND_EVENT;
          end
          srv_kind_d = kind;
          srv_tot    = SRV_PKT_BYTES;
        end
        // Gather the reply length from bytes four to seven
        if (kind == KIND_REPLY && srv_count_q >= SrvCntW'(4) &&
            srv_count_q <= SrvCntW'(7)) begin
          acc_now = (srv_count_q == SrvCntW'(4)) ? {24'd0, b}
                                                 : {srv_len_acc_q[23:0], b};
          srv_len_acc_d = acc_now;
          if (srv_count_q == SrvCntW'(7)) begin
            len32 = endian_q ? {acc_now[7:0], acc_now[15:8], acc_now[23:16],
                                acc_now[31:24]}
                             : acc_now;
            len32     = len32 & LenMask;
            reply_tot = 35'd32 + {1'b0, len32, 2'b00};
            srv_tot   = reply_tot[34] ? SRV_CNT_MAX : reply_tot[SrvCntW-1:0];
          end
        end
      end
      last = ({1'b0, srv_count_q} + (SrvCntW+1)'(1)) >= {1'b0, srv_tot};
      if (last) begin
        srv_count_d = '0;
        srv_phase_d = SRV_PACKETS;
        srv_total_d = SRV_PKT_BYTES;
      end else begin
        srv_count_d = srv_count_q + SrvCntW'(1);
        srv_total_d = srv_tot;
      end
    end

    result_o.direction     = beat_i.from_server;
    result_o.byte_out      = b;
    result_o.packet_kind   = kind;
    result_o.byte_offset   = beat_i.from_server ? srv_count_q
                                                : SrvCntW'(cli_count_q);
    result_o.last_byte     = last;
    result_o.bad_length    = bad;
    result_o.little_endian = endian_d;
  end

  // Advance framing state as the byte moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cli_phase_q    <= CLI_SETUP;
      cli_count_q    <= '0;
      cli_total_q    <= CLI_SETUP_HDR;
      cli_len_lo_q   <= '0;
      cli_name_len_q <= '0;
      srv_phase_q    <= SRV_SETUP;
      srv_count_q    <= '0;
      srv_total_q    <= SRV_SETUP_HDR;
      srv_kind_q     <= KIND_SETUP_REPLY;
      srv_len_acc_q  <= '0;
      endian_q       <= 1'b0;
    end else if (advance_i) begin
      cli_phase_q    <= cli_phase_d;
      cli_count_q    <= cli_count_d;
      cli_total_q    <= cli_total_d;
      cli_len_lo_q   <= cli_len_lo_d;
      cli_name_len_q <= cli_name_len_d;
      srv_phase_q    <= srv_phase_d;
      srv_count_q    <= srv_count_d;
      srv_total_q    <= srv_total_d;
      srv_kind_q     <= srv_kind_d;
      srv_len_acc_q  <= srv_len_acc_d;
      endian_q       <= endian_d;
    end
  end

endmodule

// ===== tb/sv/x11_stream_framer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x11_stream_framer_test: self-checking bench for the X11 stream framer
// Feeds interleaved client and server byte streams through the framer.
// A short table covers reset framing, the byte-order switch and a zero-length
// request. Random well-formed packets with random content follow, ending with
// a reply whose length overflows the offset counter. Every output beat is
// checked field by field against the table's tags or an in-bench framing model.
// ----------------------------------------------------------------------------
module x11_stream_framer_test;
  import x11sf_pkg::*;

  localparam int unsigned REPLY_BITS   = 32;
  localparam int unsigned RANDOM_BEATS = 1450;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned HOLD_AFTER   = 60;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned PLAN_LEN     = 28;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_beat_t  in_data_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_beat_t out_data_o;

  x11_stream_framer #(
    .REPLY_LEN_BITS(REPLY_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // Framing model state, at reset values
  cli_phase_e  cli_ph   = CLI_SETUP;
  logic [17:0] cli_pos  = '0;
  logic [17:0] cli_len  = 18'd12;
  logic [7:0]  cli_lo   = '0;
  logic [15:0] cli_name = '0;
  srv_phase_e  srv_ph   = SRV_SETUP;
  logic [33:0] srv_pos  = '0;
  logic [33:0] srv_len  = 34'd8;
  pkt_kind_e   srv_pkt  = KIND_SETUP_REPLY;
  logic [31:0] srv_word = '0;
  logic        order_le = 1'b0;

  out_beat_t   beats_due [$];
  logic [7:0]  cli_bytes [$];
  logic [7:0]  srv_bytes [$];

  int unsigned tx_idle_pct = 12;
  int unsigned rx_idle_pct = 85;
  int unsigned err_cnt     = 0;
  int unsigned n_sent      = 0;
  int unsigned n_checked   = 0;
  int unsigned n_bad       = 0;
  int unsigned n_ends      = 0;
  int unsigned quiet_cnt   = 0;
  int unsigned hold_left   = 0;
  bit          hold_done   = 1'b0;
  out_beat_t   due_beat;

  // Directed stimulus; rows with typed set carry their expected tags
  typedef struct packed {
    logic       dir;
    logic [7:0] data;
    logic       typed;
    pkt_kind_e  kind;
    logic [4:0] pos;
    logic       last;
    logic       bad;
    logic       le;
  } plan_row_t;

  plan_row_t plan [0:PLAN_LEN-1] = '{
    // server setup reply before any client byte: big-endian, length 0
    '{1'b1, 8'h01, 1'b1, KIND_SETUP_REPLY, 5'd0,  1'b0, 1'b0, 1'b0},
    '{1'b1, 8'hFF, 1'b1, KIND_SETUP_REPLY, 5'd1,  1'b0, 1'b0, 1'b0},
    '{1'b1, 8'h00, 1'b1, KIND_SETUP_REPLY, 5'd2,  1'b0, 1'b0, 1'b0},
    '{1'b1, 8'h0B, 1'b1, KIND_SETUP_REPLY, 5'd3,  1'b0, 1'b0, 1'b0},
    '{1'b1, 8'h00, 1'b1, KIND_SETUP_REPLY, 5'd4,  1'b0, 1'b0, 1'b0},
    '{1'b1, 8'h00, 1'b1, KIND_SETUP_REPLY, 5'd5,  1'b0, 1'b0, 1'b0},
    '{1'b1, 8'h00, 1'b1, KIND_SETUP_REPLY, 5'd6,  1'b0, 1'b0, 1'b0},
    '{1'b1, 8'h00, 1'b1, KIND_SETUP_REPLY, 5'd7,  1'b1, 1'b0, 1'b0},
    // client setup message opening with 'l', empty name and data
    '{1'b0, 8'h6C, 1'b1, KIND_SETUP_MSG,   5'd0,  1'b0, 1'b0, 1'b1},
    '{1'b0, 8'hFF, 1'b1, KIND_SETUP_MSG,   5'd1,  1'b0, 1'b0, 1'b1},
    '{1'b0, 8'h0B, 1'b1, KIND_SETUP_MSG,   5'd2,  1'b0, 1'b0, 1'b1},
    '{1'b0, 8'h00, 1'b1, KIND_SETUP_MSG,   5'd3,  1'b0, 1'b0, 1'b1},
    '{1'b0, 8'h00, 1'b1, KIND_SETUP_MSG,   5'd4,  1'b0, 1'b0, 1'b1},
    '{1'b0, 8'h00, 1'b1, KIND_SETUP_MSG,   5'd5,  1'b0, 1'b0, 1'b1},
    '{1'b0, 8'h00, 1'b1, KIND_SETUP_MSG,   5'd6,  1'b0, 1'b0, 1'b1},
    '{1'b0, 8'h00, 1'b1, KIND_SETUP_MSG,   5'd7,  1'b0, 1'b0, 1'b1},
    '{1'b0, 8'h00, 1'b1, KIND_SETUP_MSG,   5'd8,  1'b0, 1'b0, 1'b1},
    '{1'b0, 8'h00, 1'b1, KIND_SETUP_MSG,   5'd9,  1'b0, 1'b0, 1'b1},
    '{1'b0, 8'hFF, 1'b1, KIND_SETUP_MSG,   5'd10, 1'b0, 1'b0, 1'b1},
    '{1'b0, 8'h00, 1'b1, KIND_SETUP_MSG,   5'd11, 1'b1, 1'b0, 1'b1},
    // request with zero length: flagged, ends at its header
    '{1'b0, 8'h80, 1'b1, KIND_REQUEST,     5'd0,  1'b0, 1'b0, 1'b1},
    '{1'b0, 8'h00, 1'b1, KIND_REQUEST,     5'd1,  1'b0, 1'b0, 1'b1},
    '{1'b0, 8'h00, 1'b1, KIND_REQUEST,     5'd2,  1'b0, 1'b0, 1'b1},
    '{1'b0, 8'h00, 1'b1, KIND_REQUEST,     5'd3,  1'b1, 1'b1, 1'b1},
    // one-word request, checked by the model
    '{1'b0, 8'h7F, 1'b0, KIND_REQUEST,     5'd0,  1'b0, 1'b0, 1'b0},
    '{1'b0, 8'hFF, 1'b0, KIND_REQUEST,     5'd0,  1'b0, 1'b0, 1'b0},
    '{1'b0, 8'h01, 1'b0, KIND_REQUEST,     5'd0,  1'b0, 1'b0, 1'b0},
    '{1'b0, 8'h00, 1'b0, KIND_REQUEST,     5'd0,  1'b0, 1'b0, 1'b0}
  };

  // Build a 16-bit word from two bytes in arrival order
  function automatic logic [15:0] join16(input logic [7:0] first, input logic [7:0] second);
    return order_le ? {second, first} : {first, second};
  endfunction

  function automatic int unsigned up4(input logic [15:0] n);
    return (32'(n) + 32'd3) & ~32'd3;
  endfunction

  // Tag one byte and advance the framing state of its direction
  function automatic out_beat_t frame_byte(input in_beat_t beat);
    out_beat_t   res;
    logic [7:0]  b;
    logic [17:0] cpos;
    logic [33:0] spos;
    logic [15:0] len16;
    logic [31:0] len32;
    logic [35:0] span;
    b               = beat.data_byte;
    res             = '0;
    res.direction   = beat.from_server;
    res.byte_out    = b;
    if (!beat.from_server) begin
      cpos = cli_pos;
      if (cli_ph == CLI_SETUP) begin
        res.packet_kind = KIND_SETUP_MSG;
        if (cpos == 0) order_le = (b == ASCII_LOWER_L);
        if (cpos == 6 || cpos == 8) cli_lo = b;
        if (cpos == 7) cli_name = join16(cli_lo, b);
        if (cpos == 9) cli_len = 18'(12 + up4(cli_name) + up4(join16(cli_lo, b)));
      end else begin
        res.packet_kind = KIND_REQUEST;
        if (cpos == 2) cli_lo = b;
        if (cpos == 3) begin
          len16          = join16(cli_lo, b);
          res.bad_length = (len16 == 16'd0);
          cli_len        = (len16 == 16'd0) ? 18'd4 : {len16, 2'b00};
        end
      end
      res.byte_offset = 34'(cpos);
      res.last_byte   = (19'(cpos) + 19'd1 >= 19'(cli_len));
      if (res.last_byte) begin
        cli_pos = '0;
        cli_ph  = CLI_REQUEST;
        cli_len = 18'd4;
      end else begin
        cli_pos = cpos + 18'd1;
      end
    end else begin
      spos = srv_pos;
      if (srv_ph == SRV_SETUP) begin
        res.packet_kind = KIND_SETUP_REPLY;
        if (spos == 6) srv_word = {24'd0, b};
        if (spos == 7) srv_len = 34'd8 + {16'd0, join16(srv_word[7:0], b), 2'b00};
      end else begin
        if (spos == 0) begin
          srv_pkt = (b == SRV_CODE_ERROR) ? KIND_ERROR :
                    (b == SRV_CODE_REPLY) ? KIND_REPLY : KIND_EVENT;
          srv_len = SRV_PKT_BYTES;
        end
        res.packet_kind = srv_pkt;
        // reply length arrives in bytes 4..7; saturate the packet size
        if (srv_pkt == KIND_REPLY && spos >= 4 && spos <= 7) begin
          srv_word = (spos == 4) ? {24'd0, b} : {srv_word[23:0], b};
          if (spos == 7) begin
            len32 = order_le ? {srv_word[7:0], srv_word[15:8], srv_word[23:16],
                                srv_word[31:24]} : srv_word;
            len32 = len32 & 32'((64'd1 << REPLY_BITS) - 64'd1);
            span  = 36'd32 + {2'b00, len32, 2'b00};
            srv_len = (span > 36'(SRV_CNT_MAX)) ? SRV_CNT_MAX : span[33:0];
          end
        end
      end
      res.byte_offset = spos;
      res.last_byte   = ({1'b0, spos} + 35'd1 >= {1'b0, srv_len});
      if (res.last_byte) begin
        srv_pos = '0;
        srv_ph  = SRV_PACKETS;
        srv_len = SRV_PKT_BYTES;
      end else begin
        srv_pos = spos + 34'd1;
      end
    end
    res.little_endian = order_le;
    return res;
  endfunction

  // Offer one beat, hold it until taken, then log what it must produce
  task automatic feed(input in_beat_t beat, input bit typed, input out_beat_t typed_beat);
    out_beat_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    n_sent++;
    predicted = frame_byte(beat);
    beats_due.push_back(typed ? typed_beat : predicted);
  endtask

  task automatic feed_from(input bit from_srv);
    in_beat_t beat;
    beat.from_server = from_srv;
    beat.data_byte   = from_srv ? srv_bytes.pop_front() : cli_bytes.pop_front();
    feed(beat, 1'b0, '0);
  endtask

  // Queue one request: mostly short, some empty, a few long
  task automatic queue_request();
    int unsigned pick;
    int unsigned total;
    logic [15:0] words;
    pick = $urandom_range(99);
    if (pick < 8)       words = 16'd0;
    else if (pick < 95) words = 16'($urandom_range(8, 1));
    else                words = 16'($urandom_range(40, 9));
    total = (words == 16'd0) ? 4 : 4 * words;
    for (int k = 0; k < total; k++) begin
      if (k == 2)      cli_bytes.push_back(order_le ? words[7:0] : words[15:8]);
      else if (k == 3) cli_bytes.push_back(order_le ? words[15:8] : words[7:0]);
      else             cli_bytes.push_back(8'($urandom));
    end
  endtask

  // Queue one server packet; huge gives a reply whose size overflows
  task automatic queue_server_packet(input bit huge);
    int unsigned pick;
    int unsigned total;
    logic [7:0]  code;
    logic [31:0] words;
    pick = $urandom_range(99);
    if (huge || pick < 35) code = SRV_CODE_REPLY;
    else if (pick < 65)    code = SRV_CODE_ERROR;
    else                   code = 8'($urandom_range(255, 2));
    if (huge)                         words = 32'hFFFF_FFFF;
    else if ($urandom_range(9) == 0)  words = $urandom_range(40, 7);
    else                              words = $urandom_range(6);
    if (huge)                         total = 40;
    else if (code == SRV_CODE_REPLY)  total = 32 + 4 * words;
    else                              total = 32;
    for (int k = 0; k < total; k++) begin
      if (k == 0)
        srv_bytes.push_back(code);
      else if (code == SRV_CODE_REPLY && k >= 4 && k <= 7)
        srv_bytes.push_back(order_le ? words[8*(k-4) +: 8] : words[8*(7-k) +: 8]);
      else
        srv_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic note_mismatch(input string field, input logic [33:0] want,
                               input logic [33:0] got);
    err_cnt++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  // Receiver: random stalls, plus one long hold-off to back up the pipe
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (!hold_done && n_checked >= HOLD_AFTER) begin
      out_ready_i <= 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      hold_done    = 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Check each output beat taken at the coming edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (beats_due.size() == 0) begin
        err_cnt++;
        $display("%0t: result with none expected, actual %h", $time, out_data_o);
      end else begin
        due_beat = beats_due.pop_front();
        if (out_data_o.direction !== due_beat.direction)
          note_mismatch("direction", due_beat.direction, out_data_o.direction);
        if (out_data_o.byte_out !== due_beat.byte_out)
          note_mismatch("byte_out", due_beat.byte_out, out_data_o.byte_out);
        if (out_data_o.packet_kind !== due_beat.packet_kind)
          note_mismatch("packet_kind", due_beat.packet_kind, out_data_o.packet_kind);
        if (out_data_o.byte_offset !== due_beat.byte_offset)
          note_mismatch("byte_offset", due_beat.byte_offset, out_data_o.byte_offset);
        if (out_data_o.last_byte !== due_beat.last_byte)
          note_mismatch("last_byte", due_beat.last_byte, out_data_o.last_byte);
        if (out_data_o.bad_length !== due_beat.bad_length)
          note_mismatch("bad_length", due_beat.bad_length, out_data_o.bad_length);
        if (out_data_o.little_endian !== due_beat.little_endian)
          note_mismatch("little_endian", due_beat.little_endian, out_data_o.little_endian);
        if (due_beat.bad_length) n_bad++;
        if (due_beat.last_byte)  n_ends++;
      end
      n_checked++;
    end
  end

  // Watchdog: give up when nothing moves for too long
  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cnt = 0;
    end else begin
      quiet_cnt++;
      if (quiet_cnt >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    in_beat_t  beat;
    out_beat_t typed_beat;
    bit        from_srv;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (plan[r]) begin
      beat.from_server          = plan[r].dir;
      beat.data_byte            = plan[r].data;
      typed_beat                = '0;
      typed_beat.direction      = plan[r].dir;
      typed_beat.byte_out       = plan[r].data;
      typed_beat.packet_kind    = plan[r].kind;
      typed_beat.byte_offset    = 34'(plan[r].pos);
      typed_beat.last_byte      = plan[r].last;
      typed_beat.bad_length     = plan[r].bad;
      typed_beat.little_endian  = plan[r].le;
      feed(beat, plan[r].typed, typed_beat);
    end

    // Random packets on both directions, idling shifting between sides
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == RANDOM_BEATS / 3) begin
        tx_idle_pct = 85;
        rx_idle_pct = 12;
      end
      if (i == 2 * RANDOM_BEATS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      from_srv = $urandom_range(1);
      if (from_srv && srv_bytes.size() == 0) queue_server_packet(1'b0);
      if (!from_srv && cli_bytes.size() == 0) queue_request();
      feed_from(from_srv);
    end

    // Finish open packets, then a reply too long to ever end
    queue_server_packet(1'b1);
    while (srv_bytes.size() + cli_bytes.size() != 0) begin
      from_srv = (cli_bytes.size() == 0) || (srv_bytes.size() != 0 && $urandom_range(1));
      feed_from(from_srv);
    end
    in_valid_i <= 1'b0;

    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Framed %0d bytes over both directions, %0d results checked.", n_sent, n_checked);
    $display("Saw %0d packet ends and %0d zero-length requests; last reply saturated.",
             n_ends, n_bad);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/x11sf_pkg.sv
design/x11sf_core.sv
design/x11_stream_framer.sv
tb/sv/x11_stream_framer_test.sv
